/* src/fasp_pkg.sv */
// ----------------------------------------------------------------------------
// fasp_pkg
// Types, constants and pixel shading functions for the ascii shade preview.
// ----------------------------------------------------------------------------
package fasp_pkg;

    localparam int DIM_W        = 13;
    localparam int MAX_DIM      = 4096;
    localparam int DVD_W        = 2 * DIM_W;
    localparam int CNT_W        = $clog2(DVD_W + 1);
    localparam int LUMA_W       = 15;
    localparam int SHADE_LEVELS = 10;
    localparam int Q_DEPTH      = 4;
    localparam int Q_AW         = $clog2(Q_DEPTH);
    localparam int PADDR_W      = 4;
    localparam int PDATA_W      = 32;

    localparam logic [1:0] FMT_RGB565 = 2'd0;
    localparam logic [1:0] FMT_BGRA   = 2'd1;
    localparam logic [1:0] FMT_RGBA   = 2'd2;

    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MAX_WIDTH    = 2'd2;
    localparam logic [1:0] REG_PIXEL_FORMAT = 2'd3;

    localparam logic [6:0] CHAR_NEWLINE = 7'd10;

    localparam logic [6:0] RAMP [SHADE_LEVELS] = '{
        7'd32, 7'd46, 7'd58, 7'd45, 7'd61, 7'd43, 7'd42, 7'd35, 7'd37, 7'd64
    };

    // smallest luma for each ramp step n, n*25500/9 rounded up
    localparam logic [LUMA_W-1:0] SHADE_STEP [SHADE_LEVELS-1] = '{
        15'd2834, 15'd5667, 15'd8500, 15'd11334, 15'd14167,
        15'd17000, 15'd19834, 15'd22667, 15'd25500
    };

    typedef struct packed {
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic [DIM_W-1:0] ow;
        logic             zero;
    } dims_t;

    typedef struct packed {
        logic [7:0] byte_zero;
        logic [7:0] byte_one;
        logic [7:0] byte_two;
        logic       eol;
    } entry_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DIM_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic [DVD_W-1:0] quotient;
        logic [DIM_W-1:0] remainder;
    } div_rsp_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        return (32'(v) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : v;
    endfunction

    // x*255/31 = 8x + 7x/31, the last term by reciprocal
    function automatic logic [7:0] expand5(input logic [4:0] x);
        logic [7:0]  t;
        logic [15:0] p;
        t = 8'(x) * 8'd7;
        p = 16'(t) * 16'd265;
        return {x, 3'b000} + 8'(p[15:13]);
    endfunction

    // x*255/63 = 4x + x/21
    function automatic logic [7:0] expand6(input logic [5:0] x);
        logic [1:0] f;
        if (x >= 6'd63)
            f = 2'd3;
        else if (x >= 6'd42)
            f = 2'd2;
        else if (x >= 6'd21)
            f = 2'd1;
        else
            f = 2'd0;
        return {x, 2'b00} + 8'(f);
    endfunction

    function automatic logic [LUMA_W-1:0] luma_of(input logic [1:0] fmt,
                                                  input entry_t e);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        case (fmt)
            FMT_RGB565:
            begin
                r = expand5(e.byte_one[7:3]);
                g = expand6({e.byte_one[2:0], e.byte_zero[7:5]});
                b = expand5(e.byte_zero[4:0]);
            end
            FMT_BGRA:
            begin
                b = e.byte_zero;
                g = e.byte_one;
                r = e.byte_two;
            end
            default:
            begin
                r = e.byte_zero;
                g = e.byte_one;
                b = e.byte_two;
            end
        endcase
        return LUMA_W'(r) * 15'd30 + LUMA_W'(g) * 15'd59 + LUMA_W'(b) * 15'd11;
    endfunction

    function automatic logic [3:0] shade_index(input logic [LUMA_W-1:0] luma);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < SHADE_LEVELS - 1; i++)
        begin
            if (luma >= SHADE_STEP[i])
                n = n + 4'd1;
        end
        return n;
    endfunction

endpackage

/* src/fasp_div.sv */
// ----------------------------------------------------------------------------
// fasp_div
// Restoring divider, one quotient bit per cycle, for the frame start sizes.
// ----------------------------------------------------------------------------
module fasp_div (
    input  logic                clk,
    input  logic                rst_n,
    input  fasp_pkg::div_req_t  req,
    output fasp_pkg::div_rsp_t  rsp
);
    import fasp_pkg::*;

    logic [DVD_W-1:0] quo_reg;
    logic [DIM_W-1:0] rem_reg;
    logic [DIM_W-1:0] dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DIM_W:0]   trial;
    logic             fits;
    logic             busy;

    assign busy  = (cnt_reg != '0);
    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (req.start)
            cnt_reg <= CNT_W'(DVD_W);
        else if (busy)
            cnt_reg <= cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dsr_reg <= req.divisor;
        end
        else if (busy)
        begin
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
            rem_reg <= fits ? DIM_W'(trial - {1'b0, dsr_reg}) : trial[DIM_W-1:0];
        end
    end

    assign rsp.busy      = busy;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

/* src/fasp_front.sv */
// ----------------------------------------------------------------------------
// fasp_front
// Tracks the source position, picks nearest-neighbour samples and queues them.
// ----------------------------------------------------------------------------
module fasp_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                restart,
    input  fasp_pkg::dims_t     dims,
    input  logic                pixel_valid,
    output logic                pixel_ready,
    input  logic [7:0]          byte_zero,
    input  logic [7:0]          byte_one,
    input  logic [7:0]          byte_two,
    output logic                push,
    output fasp_pkg::entry_t    push_data,
    input  logic                full
);
    import fasp_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_MUL     = 9'b000000010,
        ST_DIV_OH  = 9'b000000100,
        ST_WAIT_OH = 9'b000001000,
        ST_DIV_SW  = 9'b000010000,
        ST_WAIT_SW = 9'b000100000,
        ST_DIV_SH  = 9'b001000000,
        ST_WAIT_SH = 9'b010000000,
        ST_STEP    = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [DIM_W-1:0] src_col_reg;
    logic [DIM_W-1:0] src_row_reg;
    logic [DIM_W-1:0] pc_reg;
    logic [DIM_W-1:0] pr_reg;
    logic [DIM_W-1:0] nsc_reg;
    logic [DIM_W-1:0] ncr_reg;
    logic [DIM_W-1:0] nsr_reg;
    logic [DIM_W-1:0] nrr_reg;
    logic [DIM_W-1:0] oh_reg;
    logic [DIM_W-1:0] sw_reg;
    logic [DIM_W-1:0] rw_reg;
    logic [DIM_W-1:0] sh_reg;
    logic [DIM_W-1:0] rh_reg;
    logic [DVD_W-1:0] prod_reg;

    logic [DIM_W-1:0] pc_next;
    logic [DIM_W-1:0] pr_next;
    logic [DIM_W-1:0] nsc_next;
    logic [DIM_W-1:0] ncr_next;
    logic [DIM_W-1:0] nsr_next;
    logic [DIM_W-1:0] nrr_next;

    logic [DIM_W:0]     src_col_inc;
    logic [DIM_W:0]     src_row_inc;
    logic [DIM_W:0]     pc_inc;
    logic [DIM_W:0]     col_sum;
    logic [DIM_W:0]     row_sum;
    logic [2*DIM_W-1:0] prod;
    logic [DIM_W-1:0]   oh_q;
    logic               accept;
    logic               active;
    logic               at_origin;
    logic               sample;
    logic               eol_now;

    div_req_t div_req;
    div_rsp_t div_rsp;

    fasp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign pixel_ready = (state_reg == ST_IDLE) && !full;
    assign accept      = pixel_valid && pixel_ready;
    assign active      = accept && !dims.zero;
    assign at_origin   = (src_col_reg == '0) && (src_row_reg == '0);

    assign src_col_inc = {1'b0, src_col_reg} + (DIM_W+1)'(1);
    assign src_row_inc = {1'b0, src_row_reg} + (DIM_W+1)'(1);
    assign pc_inc      = {1'b0, pc_reg} + (DIM_W+1)'(1);
    assign col_sum     = {1'b0, ncr_reg} + {1'b0, rw_reg};
    assign row_sum     = {1'b0, nrr_reg} + {1'b0, rh_reg};
    assign eol_now     = (pc_inc >= {1'b0, dims.ow});
    assign prod        = DVD_W'(dims.h) * DVD_W'(dims.ow);
    assign oh_q        = div_rsp.quotient[DIM_W:1];

    assign sample = (pr_reg < oh_reg) && (pc_reg < dims.ow) &&
                    (src_row_reg == nsr_reg) && (src_col_reg == nsc_reg);

    assign push                = active && (at_origin || sample);
    assign push_data.byte_zero = byte_zero;
    assign push_data.byte_one  = byte_one;
    assign push_data.byte_two  = byte_two;
    assign push_data.eol       = at_origin ? (dims.ow == DIM_W'(1)) : eol_now;

    // advance to the next sample position: quotient and remainder stepping
    always_comb
    begin
        pc_next  = pc_reg;
        pr_next  = pr_reg;
        nsc_next = nsc_reg;
        ncr_next = ncr_reg;
        nsr_next = nsr_reg;
        nrr_next = nrr_reg;
        if (!eol_now)
        begin
            pc_next = pc_inc[DIM_W-1:0];
            if (col_sum >= {1'b0, dims.ow})
            begin
                nsc_next = nsc_reg + sw_reg + DIM_W'(1);
                ncr_next = DIM_W'(col_sum - {1'b0, dims.ow});
            end
            else
            begin
                nsc_next = nsc_reg + sw_reg;
                ncr_next = col_sum[DIM_W-1:0];
            end
        end
        else
        begin
            pc_next  = '0;
            nsc_next = '0;
            ncr_next = '0;
            pr_next  = pr_reg + DIM_W'(1);
            if (row_sum >= {1'b0, oh_reg})
            begin
                nsr_next = nsr_reg + sh_reg + DIM_W'(1);
                nrr_next = DIM_W'(row_sum - {1'b0, oh_reg});
            end
            else
            begin
                nsr_next = nsr_reg + sh_reg;
                nrr_next = row_sum[DIM_W-1:0];
            end
        end
    end

    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        state_next       = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (active && at_origin)
                    state_next = ST_MUL;
            end
            ST_MUL:
                state_next = ST_DIV_OH;
            ST_DIV_OH:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = prod_reg;
                div_req.divisor  = dims.w;
                state_next       = ST_WAIT_OH;
            end
            ST_WAIT_OH:
            begin
                if (!div_rsp.busy)
                    state_next = ST_DIV_SW;
            end
            ST_DIV_SW:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DVD_W'(dims.w);
                div_req.divisor  = dims.ow;
                state_next       = ST_WAIT_SW;
            end
            ST_WAIT_SW:
            begin
                if (!div_rsp.busy)
                    state_next = ST_DIV_SH;
            end
            ST_DIV_SH:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DVD_W'(dims.h);
                div_req.divisor  = oh_reg;
                state_next       = ST_WAIT_SH;
            end
            ST_WAIT_SH:
            begin
                if (!div_rsp.busy)
                    state_next = ST_STEP;
            end
            ST_STEP:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_col_reg <= '0;
            src_row_reg <= '0;
            pc_reg      <= '0;
            pr_reg      <= '0;
            nsc_reg     <= '0;
            ncr_reg     <= '0;
            nsr_reg     <= '0;
            nrr_reg     <= '0;
            oh_reg      <= '0;
        end
        else
        begin
            if (restart)
            begin
                src_col_reg <= '0;
                src_row_reg <= '0;
            end
            else if (active)
            begin
                if (src_col_inc >= {1'b0, dims.w})
                begin
                    src_col_reg <= '0;
                    if (src_row_inc >= {1'b0, dims.h})
                        src_row_reg <= '0;
                    else
                        src_row_reg <= src_row_inc[DIM_W-1:0];
                end
                else
                    src_col_reg <= src_col_inc[DIM_W-1:0];
            end

            // frame start: the first sample is taken now, its step waits for
            // the divider results
            if (active && at_origin)
            begin
                pc_reg  <= '0;
                pr_reg  <= '0;
                nsc_reg <= '0;
                ncr_reg <= '0;
                nsr_reg <= '0;
                nrr_reg <= '0;
            end
            else if ((active && sample) || (state_reg == ST_STEP))
            begin
                pc_reg  <= pc_next;
                pr_reg  <= pr_next;
                nsc_reg <= nsc_next;
                ncr_reg <= ncr_next;
                nsr_reg <= nsr_next;
                nrr_reg <= nrr_next;
            end

            if ((state_reg == ST_WAIT_OH) && !div_rsp.busy)
                oh_reg <= (oh_q == '0) ? DIM_W'(1) : oh_q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL)
            prod_reg <= prod[DVD_W-1:0];
        if ((state_reg == ST_WAIT_SW) && !div_rsp.busy)
        begin
            sw_reg <= div_rsp.quotient[DIM_W-1:0];
            rw_reg <= div_rsp.remainder;
        end
        if ((state_reg == ST_WAIT_SH) && !div_rsp.busy)
        begin
            sh_reg <= div_rsp.quotient[DIM_W-1:0];
            rh_reg <= div_rsp.remainder;
        end
    end

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("sample queued into a full queue");

    a_restart_origin: assert property (@(posedge clk) disable iff (!rst_n)
        restart |=> (src_col_reg == '0) && (src_row_reg == '0))
        else $error("register write did not restart the frame");

endmodule

/* src/fasp_fifo.sv */
// ----------------------------------------------------------------------------
// fasp_fifo
// Short queue of sampled pixels between the sampling front and the shader.
// ----------------------------------------------------------------------------
module fasp_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  fasp_pkg::entry_t    wdata,
    output logic                full,
    input  logic                pop,
    output fasp_pkg::entry_t    rdata,
    output logic                empty
);
    import fasp_pkg::*;

    entry_t          mem_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_AW:0]   count_reg;
    logic            do_push;
    logic            do_pop;

    assign full    = (count_reg == (Q_AW+1)'(Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + Q_AW'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + Q_AW'(1);
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + (Q_AW+1)'(1);
                2'b01:   count_reg <= count_reg - (Q_AW+1)'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (Q_AW+1)'(Q_DEPTH))
        else $error("queue fill count beyond depth");

endmodule

/* src/fasp_back.sv */
// ----------------------------------------------------------------------------
// fasp_back
// Shades queued samples into ramp characters and adds the row newline.
// ----------------------------------------------------------------------------
module fasp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          fmt,
    input  logic                empty,
    input  fasp_pkg::entry_t    rdata,
    output logic                pop,
    output logic                char_valid,
    input  logic                char_ready,
    output logic [6:0]          char_code,
    output logic                last_of_run
);
    import fasp_pkg::*;

    logic              a_valid_reg;
    logic [LUMA_W-1:0] a_luma_reg;
    logic              a_eol_reg;
    logic              out_valid_reg;
    logic              nl_pend_reg;
    logic [6:0]        char_reg;
    logic              last_reg;
    logic              take;
    logic              out_free;
    logic              a_adv;

    assign take     = out_valid_reg && char_ready;
    assign out_free = !out_valid_reg || (char_ready && !nl_pend_reg);
    assign a_adv    = a_valid_reg && out_free;
    assign pop      = !empty && (!a_valid_reg || a_adv);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            nl_pend_reg   <= 1'b0;
        end
        else
        begin
            if (pop)
                a_valid_reg <= 1'b1;
            else if (a_adv)
                a_valid_reg <= 1'b0;

            if (a_adv)
            begin
                out_valid_reg <= 1'b1;
                nl_pend_reg   <= a_eol_reg;
            end
            else if (take)
            begin
                // newline follows the shade of the row's last sample
                if (nl_pend_reg)
                    nl_pend_reg <= 1'b0;
                else
                    out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_luma_reg <= luma_of(fmt, rdata);
            a_eol_reg  <= rdata.eol;
        end
        if (a_adv)
        begin
            char_reg <= RAMP[shade_index(a_luma_reg)];
            last_reg <= !a_eol_reg;
        end
        else if (take && nl_pend_reg)
        begin
            char_reg <= CHAR_NEWLINE;
            last_reg <= 1'b1;
        end
    end

    assign char_valid  = out_valid_reg;
    assign char_code   = char_reg;
    assign last_of_run = last_reg;

    a_newline_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !last_reg) |-> nl_pend_reg)
        else $error("shade without last flag but no newline pending");

    a_pend_has_valid: assert property (@(posedge clk) disable iff (!rst_n)
        nl_pend_reg |-> out_valid_reg)
        else $error("newline pending with empty output register");

endmodule

/* src/frame_ascii_shade_preview.sv */
// ----------------------------------------------------------------------------
// frame_ascii_shade_preview
// Ascii shade preview of a raster pixel stream with an APB register port.
// ----------------------------------------------------------------------------
// Pixels enter on pixel_valid/pixel_ready in raster order, one request per
// pixel with its three bytes. Characters leave on char_valid/char_ready;
// last_of_run marks the final character that a pixel causes, and a row's last
// sample gives a shade character followed by a newline.
// char_valid rises once a sampled pixel has passed the queue, the luma stage
// and the output register; its newline is presented in the cycle after the
// shade is accepted. Outside frame start one pixel is taken per cycle while
// the four-entry sample queue has room. The pixel at position 0,0 runs three
// serial divisions of 26 quotient bits each (preview height and both sample
// steps), so pixel_ready stays low until they and the sample step are done.
// When the receiver stalls, the output register holds, the queue fills and
// pixel_ready drops; no character is lost.
// Reset clears the frame position and loads 640x480, 80 columns and RGBA
// byte order. Any register write restarts the frame at position 0,0; while
// any size register is zero, pixels are taken and dropped.
// ----------------------------------------------------------------------------
module frame_ascii_shade_preview (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fasp_pkg::PADDR_W-1:0]  paddr,
    input  logic [fasp_pkg::PDATA_W-1:0]  pwdata,
    output logic [fasp_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          pixel_valid,
    output logic                          pixel_ready,
    input  logic [7:0]                    byte_zero,
    input  logic [7:0]                    byte_one,
    input  logic [7:0]                    byte_two,
    output logic                          char_valid,
    input  logic                          char_ready,
    output logic [6:0]                    char_code,
    output logic                          last_of_run
);
    import fasp_pkg::*;

    logic [DIM_W-1:0] frame_width_reg;
    logic [DIM_W-1:0] frame_height_reg;
    logic [DIM_W-1:0] max_width_reg;
    logic [1:0]       pixel_format_reg;
    logic [DIM_W-1:0] w_clamped;
    logic [DIM_W-1:0] h_clamped;
    logic [DIM_W-1:0] mw_clamped;
    logic [1:0]       reg_index;
    logic             cfg_write;
    dims_t            dims;

    logic   push;
    logic   full;
    logic   pop;
    logic   empty;
    entry_t push_data;
    entry_t pop_data;

    assign pready    = 1'b1;
    assign reg_index = paddr[PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= DIM_W'(640);
            frame_height_reg <= DIM_W'(480);
            max_width_reg    <= DIM_W'(80);
            pixel_format_reg <= FMT_RGBA;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[DIM_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[DIM_W-1:0];
                REG_MAX_WIDTH:    max_width_reg    <= pwdata[DIM_W-1:0];
                REG_PIXEL_FORMAT: pixel_format_reg <= pwdata[1:0];
                default:          pixel_format_reg <= pixel_format_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_FRAME_WIDTH:  prdata = PDATA_W'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = PDATA_W'(frame_height_reg);
            REG_MAX_WIDTH:    prdata = PDATA_W'(max_width_reg);
            REG_PIXEL_FORMAT: prdata = PDATA_W'(pixel_format_reg);
            default:          prdata = '0;
        endcase
    end

    assign w_clamped  = clamp_dim(frame_width_reg);
    assign h_clamped  = clamp_dim(frame_height_reg);
    assign mw_clamped = clamp_dim(max_width_reg);

    assign dims.w    = w_clamped;
    assign dims.h    = h_clamped;
    assign dims.ow   = (w_clamped < mw_clamped) ? w_clamped : mw_clamped;
    assign dims.zero = (w_clamped == '0) || (h_clamped == '0) || (mw_clamped == '0);

    fasp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .restart     (cfg_write),
        .dims        (dims),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .byte_zero   (byte_zero),
        .byte_one    (byte_one),
        .byte_two    (byte_two),
        .push        (push),
        .push_data   (push_data),
        .full        (full)
    );

    fasp_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (push_data),
        .full  (full),
        .pop   (pop),
        .rdata (pop_data),
        .empty (empty)
    );

    fasp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .fmt         (pixel_format_reg),
        .empty       (empty),
        .rdata       (pop_data),
        .pop         (pop),
        .char_valid  (char_valid),
        .char_ready  (char_ready),
        .char_code   (char_code),
        .last_of_run (last_of_run)
    );

endmodule

/* tb/tb_frame_ascii_shade_preview.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_frame_ascii_shade_preview
// Self-checking bench for the ascii shade preview: drives pixel requests and
// APB register writes, predicts every shade character and newline, and
// compares each character request field by field against the prediction.
// ----------------------------------------------------------------------------
module tb_frame_ascii_shade_preview;

    import fasp_pkg::*;

    typedef struct packed {
        logic [6:0] code;
        logic       last;
    } shade_char_t;

    localparam byte SHADE_RAMP [10] = '{
        8'd32, 8'd46, 8'd58, 8'd45, 8'd61, 8'd43, 8'd42, 8'd35, 8'd37, 8'd64
    };
    localparam int SETTLE_CYCLES = 150;
    localparam int RANDOM_PIXELS = 1650;
    localparam int QUIET_FROM    = 1350;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 psel        = 1'b0;
    logic                 penable     = 1'b0;
    logic                 pwrite      = 1'b0;
    logic [PADDR_W-1:0]   paddr       = '0;
    logic [PDATA_W-1:0]   pwdata      = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 pixel_valid = 1'b0;
    logic                 pixel_ready;
    logic [7:0]           byte_zero   = 8'd0;
    logic [7:0]           byte_one    = 8'd0;
    logic [7:0]           byte_two    = 8'd0;
    logic                 char_valid;
    logic                 char_ready  = 1'b0;
    logic [6:0]           char_code;
    logic                 last_of_run;

    // register shadow, reset values
    int unsigned frame_w_q = 640;
    int unsigned frame_h_q = 480;
    int unsigned max_w_q   = 80;
    logic [1:0]  fmt_q     = FMT_RGBA;

    // frame position and sampling state
    int unsigned src_col  = 0;
    int unsigned src_row  = 0;
    int unsigned pv_col   = 0;
    int unsigned pv_row   = 0;
    int unsigned samp_col = 0;
    int unsigned samp_row = 0;
    int unsigned pv_rows  = 0;

    shade_char_t pending_chars [$];
    shade_char_t oldest_char;
    int          errors_seen = 0;
    bit          idle_on     = 1'b1;

    frame_ascii_shade_preview dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .byte_zero   (byte_zero),
        .byte_one    (byte_one),
        .byte_two    (byte_two),
        .char_valid  (char_valid),
        .char_ready  (char_ready),
        .char_code   (char_code),
        .last_of_run (last_of_run)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int unsigned limit_dim(input int unsigned v);
        return (v > MAX_DIM) ? MAX_DIM : v;
    endfunction

    function automatic void restart_frame();
        src_col  = 0;
        src_row  = 0;
        pv_col   = 0;
        pv_row   = 0;
        samp_col = 0;
        samp_row = 0;
    endfunction

    function automatic logic [6:0] shade_char(input logic [7:0] b0, input logic [7:0] b1,
                                              input logic [7:0] b2);
        int unsigned v;
        int unsigned r;
        int unsigned g;
        int unsigned b;
        int unsigned luma;
        v = {b1, b0};
        if (fmt_q == FMT_RGB565)
        begin
            r = ((v >> 11) & 31) * 255 / 31;
            g = ((v >> 5) & 63) * 255 / 63;
            b = (v & 31) * 255 / 31;
        end
        else if (fmt_q == FMT_BGRA)
        begin
            b = b0;
            g = b1;
            r = b2;
        end
        else
        begin
            r = b0;
            g = b1;
            b = b2;
        end
        luma = r * 30 + g * 59 + b * 11;
        return SHADE_RAMP[luma * 9 / 25500][6:0];
    endfunction

    // works out the characters one accepted pixel causes
    task automatic predict_pixel(input logic [7:0] b0, input logic [7:0] b1,
                                 input logic [7:0] b2);
        int unsigned w;
        int unsigned h;
        int unsigned mw;
        int unsigned ow;
        int unsigned oh;
        logic [6:0]  c;
        w  = limit_dim(frame_w_q);
        h  = limit_dim(frame_h_q);
        mw = limit_dim(max_w_q);
        if (w == 0 || h == 0 || mw == 0)
            return;
        ow = (w < mw) ? w : mw;
        if (src_col >= w || src_row >= h)
            restart_frame();
        if (src_col == 0 && src_row == 0)
        begin
            oh       = h * ow / w / 2;
            pv_rows  = (oh == 0) ? 1 : oh;
            pv_col   = 0;
            pv_row   = 0;
            samp_col = 0;
            samp_row = 0;
        end
        if (pv_row < pv_rows && pv_col < ow && src_row == samp_row && src_col == samp_col)
        begin
            c = shade_char(b0, b1, b2);
            pv_col++;
            if (pv_col < ow)
            begin
                samp_col = pv_col * w / ow;
                pending_chars.push_back('{code: c, last: 1'b1});
            end
            else
            begin
                pending_chars.push_back('{code: c, last: 1'b0});
                pending_chars.push_back('{code: CHAR_NEWLINE, last: 1'b1});
                pv_col   = 0;
                samp_col = 0;
                pv_row++;
                samp_row = pv_row * h / pv_rows;
            end
        end
        src_col++;
        if (src_col >= w)
        begin
            src_col = 0;
            src_row++;
            if (src_row >= h)
                src_row = 0;
        end
    endtask

    // character check first, then prediction of a pixel taken at the same edge
    always @(posedge clk)
    begin
        if (rst_n && char_valid && char_ready)
        begin
            if (pending_chars.size() == 0)
            begin
                $error("char_code: no character expected, got %0d (last_of_run %0d)",
                       char_code, last_of_run);
                errors_seen++;
            end
            else
            begin
                oldest_char = pending_chars.pop_front();
                if (char_code !== oldest_char.code)
                begin
                    $error("char_code: expected %0d, got %0d", oldest_char.code, char_code);
                    errors_seen++;
                end
                if (last_of_run !== oldest_char.last)
                begin
                    $error("last_of_run: expected %0d, got %0d", oldest_char.last,
                           last_of_run);
                    errors_seen++;
                end
            end
        end
        if (rst_n && pixel_valid && pixel_ready)
            predict_pixel(byte_zero, byte_one, byte_two);
    end

    // receiver stalls
    always
    begin
        @(negedge clk);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            char_ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        char_ready <= 1'b1;
    end

    task automatic settle();
        pixel_valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic send_pixel(input logic [7:0] b0, input logic [7:0] b1,
                              input logic [7:0] b2);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            pixel_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        pixel_valid <= 1'b1;
        byte_zero   <= b0;
        byte_one    <= b1;
        byte_two    <= b2;
        @(posedge clk);
        while (!pixel_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // register writes only once the block has drained
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        settle();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_FRAME_WIDTH:  frame_w_q = value[12:0];
            REG_FRAME_HEIGHT: frame_h_q = value[12:0];
            REG_MAX_WIDTH:    max_w_q   = value[12:0];
            default:          fmt_q     = value[1:0];
        endcase
        restart_frame();
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic test_reset_values();
        // 640 wide, 80 columns: samples at source columns 0 and 8
        repeat (9) send_pixel(rand_byte(), rand_byte(), rand_byte());
    endtask

    task automatic test_pixel_formats();
        write_reg(REG_FRAME_WIDTH, 1);
        write_reg(REG_FRAME_HEIGHT, 1);
        write_reg(REG_MAX_WIDTH, 1);
        // one-pixel frame: every pixel is a shade plus newline and a frame wrap
        for (int f = 0; f < 4; f++)
        begin
            write_reg(REG_PIXEL_FORMAT, f);
            send_pixel(8'h00, 8'h00, 8'h00);
            send_pixel(8'hFF, 8'hFF, 8'hFF);
            if (f == FMT_RGBA)
            begin
                // gray levels on either side of the first ramp step
                send_pixel(8'd28, 8'd28, 8'd28);
                send_pixel(8'd29, 8'd29, 8'd29);
            end
        end
    endtask

    task automatic test_zero_sizes();
        write_reg(REG_FRAME_WIDTH, 0);
        send_pixel(rand_byte(), rand_byte(), rand_byte());
        send_pixel(rand_byte(), rand_byte(), rand_byte());
        write_reg(REG_FRAME_WIDTH, 5);
        write_reg(REG_FRAME_HEIGHT, 0);
        send_pixel(rand_byte(), rand_byte(), rand_byte());
        write_reg(REG_FRAME_HEIGHT, 4);
        write_reg(REG_MAX_WIDTH, 0);
        send_pixel(rand_byte(), rand_byte(), rand_byte());
        write_reg(REG_MAX_WIDTH, 3);
        send_pixel(rand_byte(), rand_byte(), rand_byte());
    endtask

    task automatic test_oversized_sizes();
        // all three clamp to the largest size
        write_reg(REG_FRAME_WIDTH, 32'hFFFF_FFFF);
        write_reg(REG_FRAME_HEIGHT, 5000);
        write_reg(REG_MAX_WIDTH, 8191);
        write_reg(REG_PIXEL_FORMAT, 32'hFFFF_FFFE);
        send_pixel(rand_byte(), rand_byte(), rand_byte());
        send_pixel(rand_byte(), rand_byte(), rand_byte());
        // preview height rounds to zero and is raised to one
        write_reg(REG_FRAME_WIDTH, 4096);
        write_reg(REG_FRAME_HEIGHT, 1);
        write_reg(REG_MAX_WIDTH, 4096);
        send_pixel(rand_byte(), rand_byte(), rand_byte());
        send_pixel(rand_byte(), rand_byte(), rand_byte());
    endtask

    task automatic test_random_frames();
        int          sent;
        int          sel;
        int unsigned w;
        int unsigned h;
        int unsigned mw;
        int unsigned n;
        sent = 0;
        while (sent < RANDOM_PIXELS)
        begin
            idle_on = (sent < QUIET_FROM) && ($urandom_range(0, 3) != 0);
            sel = $urandom_range(0, 11);
            if (sel == 0)
            begin
                w  = $urandom_range(1000, 8191);
                h  = $urandom_range(1, 8191);
                mw = $urandom_range(1, 8191);
                n  = $urandom_range(10, 40);
            end
            else
            begin
                w  = $urandom_range(1, 12);
                h  = $urandom_range(1, 10);
                mw = $urandom_range(1, 14);
                n  = $urandom_range(w * h, 2 * w * h + 3);
            end
            if (sel == 1)
            begin
                // one size zero: pixels are dropped
                case ($urandom_range(0, 2))
                    0:       w  = 0;
                    1:       h  = 0;
                    default: mw = 0;
                endcase
                n = 3;
            end
            write_reg(REG_FRAME_WIDTH, ($urandom & 32'hFFFF_E000) | w);
            write_reg(REG_FRAME_HEIGHT, ($urandom & 32'hFFFF_E000) | h);
            write_reg(REG_MAX_WIDTH, ($urandom & 32'hFFFF_E000) | mw);
            write_reg(REG_PIXEL_FORMAT, $urandom);
            repeat (n) send_pixel(rand_byte(), rand_byte(), rand_byte());
            if (sel != 1)
                sent += n;
        end
        idle_on = 1'b0;
    endtask

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_values();
        test_pixel_formats();
        test_zero_sizes();
        test_oversized_sizes();
        test_random_frames();
        settle();
        if (errors_seen == 0)
            $display("** frame_ascii_shade_preview: PASSED **");
        else
            $display("** frame_ascii_shade_preview: FAILED **");
        $finish;
    end

    initial
    begin
        #(40_000_000);
        $display("** frame_ascii_shade_preview: FAILED **");
        $finish;
    end

endmodule
